FILE: hw/rtl/mafh_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup tables for the MPEG audio header decoder.
// No dependencies; used by every module of the block.
package mafh_pkg;

   // Header codes
   localparam logic [10:0] SYNC_PATTERN  = 11'h7ff;
   localparam logic [1:0]  VER_MPEG25    = 2'd0;
   localparam logic [1:0]  VER_RESERVED  = 2'd1;
   localparam logic [1:0]  VER_MPEG2     = 2'd2;
   localparam logic [1:0]  VER_MPEG1     = 2'd3;
   localparam logic [1:0]  LCODE_RSVD    = 2'd0;
   localparam logic [1:0]  LCODE_LAYER3  = 2'd1;
   localparam logic [1:0]  LCODE_LAYER1  = 2'd3;
   localparam logic [3:0]  BRI_FREE      = 4'd0;
   localparam logic [3:0]  BRI_BAD       = 4'd15;
   localparam logic [1:0]  SRI_44K       = 2'd0;
   localparam logic [1:0]  SRI_48K       = 2'd1;
   localparam logic [1:0]  SRI_32K       = 2'd2;
   localparam logic [1:0]  SRI_RSVD      = 2'd3;

   // Field widths
   localparam int KBPS_W  = 9;
   localparam int KCOEF_W = 18;
   localparam int AVAIL_W = 12;
   localparam int LEN_W   = 12;
   localparam int FMT_W   = 6;
   localparam int X_W     = 29;   // kbps * coef * version scale
   localparam int BASE_W  = 16;
   localparam int RECIP_W = 30;
   localparam int RPROD_W = X_W + RECIP_W;
   localparam int BACK_W  = LEN_W + BASE_W;
   localparam int MIN_LEN = 4;

   // Layer coefficients premultiplied by 1000 (kbps to bit/s)
   localparam logic [KCOEF_W-1:0] KCOEF_L1   = 18'd12000;
   localparam logic [KCOEF_W-1:0] KCOEF_HALF = 18'd72000;
   localparam logic [KCOEF_W-1:0] KCOEF_FULL = 18'd144000;

   // Base sample rates
   localparam logic [BASE_W-1:0] RATE_44K = 16'd44100;
   localparam logic [BASE_W-1:0] RATE_48K = 16'd48000;
   localparam logic [BASE_W-1:0] RATE_32K = 16'd32000;

   // Reciprocals floor(2^RECIP_SHIFT / rate); quotient estimate is q or q-1
   localparam int RECIP_SHIFT = 44;
   localparam logic [RECIP_W-1:0] RECIP_44K =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd44100);
   localparam logic [RECIP_W-1:0] RECIP_48K =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd48000);
   localparam logic [RECIP_W-1:0] RECIP_32K =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd32000);

   // Bitrate tables in kbps, row = layer - 1 (row 3 unused)
   localparam logic [KBPS_W-1:0] KBPS_V1 [4][16] = '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{default: 9'd0}
   };
   localparam logic [KBPS_W-1:0] KBPS_V2 [4][16] = '{
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{default: 9'd0}
   };

   // Per-transaction flags and fields carried alongside the arithmetic
   typedef struct packed {
      logic               hdr_ok;
      logic               pad;
      logic               layer_one;
      logic [AVAIL_W-1:0] avail;
      logic [FMT_W-1:0]   format;
   } side_type;

   // Operands for the length arithmetic
   typedef struct packed {
      logic [KBPS_W-1:0]  kbps;
      logic [KCOEF_W-1:0] kcoef;
      logic [1:0]         dshift;
      logic [1:0]         sri;
   } calc_type;

   function automatic logic [BASE_W-1:0] base_rate(input logic [1:0] sri);
      logic [BASE_W-1:0] rate;
      unique case (sri)
         SRI_44K: rate = RATE_44K;
         SRI_48K: rate = RATE_48K;
         SRI_32K: rate = RATE_32K;
         default: rate = RATE_44K;   // reserved code, frame already rejected
      endcase
      return rate;
   endfunction

   function automatic logic [RECIP_W-1:0] rate_recip(input logic [1:0] sri);
      logic [RECIP_W-1:0] recip;
      unique case (sri)
         SRI_44K: recip = RECIP_44K;
         SRI_48K: recip = RECIP_48K;
         SRI_32K: recip = RECIP_32K;
         default: recip = RECIP_44K;
      endcase
      return recip;
   endfunction

endpackage

FILE: hw/rtl/mafh_parse.sv
`timescale 1ns / 1ps
// Stage 1: header field decode, validity checks and bitrate table lookup.
// Depends on mafh_pkg.
module mafh_parse (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [31:0]                      header_word,
   input  logic [mafh_pkg::AVAIL_W-1:0]     bytes_available,
   output logic                             out_valid,
   output mafh_pkg::side_type               out_side,
   output mafh_pkg::calc_type               out_calc
);

   logic                  valid_ff;
   mafh_pkg::side_type    side_ff, side_in;
   mafh_pkg::calc_type    calc_ff, calc_in;

   logic [10:0] sync;
   logic [1:0]  ver;
   logic [1:0]  lcode;
   logic [3:0]  bri;
   logic [1:0]  sri;
   logic [1:0]  layer;
   logic [1:0]  row;
   logic        sync_ok;
   logic        codes_ok;

   // Field split
   assign sync  = header_word[31:21];
   assign ver   = header_word[20:19];
   assign lcode = header_word[18:17];
   assign bri   = header_word[15:12];
   assign sri   = header_word[11:10];
   assign layer = 2'(3'd4 - {1'b0, lcode});
   assign row   = 2'(2'd3 - lcode);

   assign sync_ok  = (sync == mafh_pkg::SYNC_PATTERN);
   assign codes_ok = (ver != mafh_pkg::VER_RESERVED) && (lcode != mafh_pkg::LCODE_RSVD)
                     && (bri != mafh_pkg::BRI_FREE) && (bri != mafh_pkg::BRI_BAD)
                     && (sri != mafh_pkg::SRI_RSVD);

   // Decode and table lookup
   always_comb begin
      side_in.hdr_ok    = sync_ok && codes_ok
                          && (bytes_available >= mafh_pkg::AVAIL_W'(mafh_pkg::MIN_LEN));
      side_in.pad       = header_word[9];
      side_in.layer_one = (lcode == mafh_pkg::LCODE_LAYER1);
      side_in.avail     = bytes_available;
      side_in.format    = {ver, layer, sri};

      calc_in.sri = sri;
      if (ver == mafh_pkg::VER_MPEG1) begin
         calc_in.kbps = mafh_pkg::KBPS_V1[row][bri];
      end else begin
         calc_in.kbps = mafh_pkg::KBPS_V2[row][bri];
      end

      // Halved / quartered sample rate folds into the numerator as a shift
      unique case (ver)
         mafh_pkg::VER_MPEG2:  calc_in.dshift = 2'd1;
         mafh_pkg::VER_MPEG25: calc_in.dshift = 2'd2;
         default:              calc_in.dshift = 2'd0;
      endcase

      priority if (lcode == mafh_pkg::LCODE_LAYER1) begin
         calc_in.kcoef = mafh_pkg::KCOEF_L1;
      end else if (lcode == mafh_pkg::LCODE_LAYER3 && ver != mafh_pkg::VER_MPEG1) begin
         calc_in.kcoef = mafh_pkg::KCOEF_HALF;
      end else begin
         calc_in.kcoef = mafh_pkg::KCOEF_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
      calc_ff <= calc_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_calc  = calc_ff;

endmodule

FILE: hw/rtl/mafh_length.sv
`timescale 1ns / 1ps
// Stages 2 to 5: numerator product, reciprocal division with one-step
// correction, and padding / layer-I slot scaling. Depends on mafh_pkg.
module mafh_length (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  mafh_pkg::side_type            in_side,
   input  mafh_pkg::calc_type            in_calc,
   output logic                          out_valid,
   output mafh_pkg::side_type            out_side,
   output logic [mafh_pkg::LEN_W-1:0]    out_len
);

   localparam int KPROD_W = mafh_pkg::KBPS_W + mafh_pkg::KCOEF_W;

   // Stage 2: numerator
   logic                          s2_valid_ff;
   mafh_pkg::side_type            s2_side_ff;
   logic [1:0]                    s2_sri_ff;
   logic [mafh_pkg::X_W-1:0]      s2_x_ff, s2_x_in;
   logic [KPROD_W-1:0]            kprod;

   // Stage 3: quotient estimate
   logic                          s3_valid_ff;
   mafh_pkg::side_type            s3_side_ff;
   logic [1:0]                    s3_sri_ff;
   logic [mafh_pkg::X_W-1:0]      s3_x_ff;
   logic [mafh_pkg::LEN_W-1:0]    s3_q0_ff, s3_q0_in;
   logic [mafh_pkg::RPROD_W-1:0]  rprod;

   // Stage 4: back product
   logic                          s4_valid_ff;
   mafh_pkg::side_type            s4_side_ff;
   logic [1:0]                    s4_sri_ff;
   logic [mafh_pkg::X_W-1:0]      s4_x_ff;
   logic [mafh_pkg::LEN_W-1:0]    s4_q0_ff;
   logic [mafh_pkg::BACK_W-1:0]   s4_back_ff, s4_back_in;

   // Stage 5: corrected quotient and length
   logic                          s5_valid_ff;
   mafh_pkg::side_type            s5_side_ff;
   logic [mafh_pkg::LEN_W-1:0]    s5_len_ff, s5_len_in;
   logic [mafh_pkg::X_W-1:0]      remainder;
   logic                          bump;
   logic [mafh_pkg::LEN_W-1:0]    quot;
   logic [mafh_pkg::LEN_W-1:0]    slots;

   // kbps * layer coefficient, scaled for MPEG-2 / 2.5
   assign kprod   = KPROD_W'(in_calc.kbps) * KPROD_W'(in_calc.kcoef);
   assign s2_x_in = mafh_pkg::X_W'(kprod) << in_calc.dshift;

   // Reciprocal multiply; estimate is exact or one low
   assign rprod    = mafh_pkg::RPROD_W'(s2_x_ff)
                     * mafh_pkg::RPROD_W'(mafh_pkg::rate_recip(s2_sri_ff));
   assign s3_q0_in = rprod[mafh_pkg::RECIP_SHIFT +: mafh_pkg::LEN_W];

   assign s4_back_in = mafh_pkg::BACK_W'(s3_q0_ff)
                       * mafh_pkg::BACK_W'(mafh_pkg::base_rate(s3_sri_ff));

   // Correction, padding, layer-I four-byte slots
   assign remainder = s4_x_ff - mafh_pkg::X_W'(s4_back_ff);
   assign bump      = (remainder >= mafh_pkg::X_W'(mafh_pkg::base_rate(s4_sri_ff)));
   assign quot      = s4_q0_ff + mafh_pkg::LEN_W'(bump);
   assign slots     = quot + mafh_pkg::LEN_W'(s4_side_ff.pad);
   assign s5_len_in = s4_side_ff.layer_one ? {slots[mafh_pkg::LEN_W-3:0], 2'b00} : slots;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= in_valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_side_ff <= in_side;
      s2_sri_ff  <= in_calc.sri;
      s2_x_ff    <= s2_x_in;

      s3_side_ff <= s2_side_ff;
      s3_sri_ff  <= s2_sri_ff;
      s3_x_ff    <= s2_x_ff;
      s3_q0_ff   <= s3_q0_in;

      s4_side_ff <= s3_side_ff;
      s4_sri_ff  <= s3_sri_ff;
      s4_x_ff    <= s3_x_ff;
      s4_q0_ff   <= s3_q0_ff;
      s4_back_ff <= s4_back_in;

      s5_side_ff <= s4_side_ff;
      s5_len_ff  <= s5_len_in;
   end

   assign out_valid = s5_valid_ff;
   assign out_side  = s5_side_ff;
   assign out_len   = s5_len_ff;

endmodule

FILE: hw/rtl/mpeg_audio_frame_header_decode.sv
`timescale 1ns / 1ps
// MPEG audio frame header decoder, top level: input stage, length pipeline,
// final fit check and result register. Depends on mafh_pkg, mafh_parse, mafh_length.
//
// One header is taken per clock whenever start is high and busy is low; busy
// is high only while reset is asserted. Each transaction produces exactly one
// result, marked by a one-cycle rsp_valid strobe; results come back in order
// and cannot be held off by the receiver. The frame-length division is done as
// a reciprocal multiply followed by a back-multiply and one correction step,
// each multiply in its own stage.
// Rejected headers return frame_ok low with length and format code zero.
module mpeg_audio_frame_header_decode (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [31:0]                      req_header_word,
   input  logic [mafh_pkg::AVAIL_W-1:0]     req_bytes_available,
   output logic                             rsp_valid,
   output logic                             rsp_frame_ok,
   output logic [mafh_pkg::LEN_W-1:0]       rsp_frame_length,
   output logic [mafh_pkg::FMT_W-1:0]       rsp_format_code
);

   logic                          s1_valid;
   mafh_pkg::side_type            s1_side;
   mafh_pkg::calc_type            s1_calc;
   logic                          s5_valid;
   mafh_pkg::side_type            s5_side;
   logic [mafh_pkg::LEN_W-1:0]    s5_len;

   logic                          valid_ff;
   logic                          ok_ff, ok_in;
   logic [mafh_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [mafh_pkg::FMT_W-1:0]    fmt_ff, fmt_in;

   assign busy = reset;

   mafh_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (start && !busy),
      .header_word     (req_header_word),
      .bytes_available (req_bytes_available),
      .out_valid       (s1_valid),
      .out_side        (s1_side),
      .out_calc        (s1_calc)
   );

   mafh_length u_length (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_side   (s1_side),
      .in_calc   (s1_calc),
      .out_valid (s5_valid),
      .out_side  (s5_side),
      .out_len   (s5_len)
   );

   // Final accept: header good, length at least four and within available bytes
   assign ok_in  = s5_side.hdr_ok
                   && (s5_len >= mafh_pkg::LEN_W'(mafh_pkg::MIN_LEN))
                   && (s5_len <= s5_side.avail);
   assign len_in = ok_in ? s5_len : '0;
   assign fmt_in = ok_in ? s5_side.format : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s5_valid;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff  <= ok_in;
      len_ff <= len_in;
      fmt_ff <= fmt_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_ok     = ok_ff;
   assign rsp_frame_length = len_ff;
   assign rsp_format_code  = fmt_ff;

endmodule

FILE: hw/rtl/mafh_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the MPEG audio header decoder, bound to the top level.
// Depends on mafh_pkg and mpeg_audio_frame_header_decode.
module mafh_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic                             rsp_valid,
   input  logic                             rsp_frame_ok,
   input  logic [mafh_pkg::LEN_W-1:0]       rsp_frame_length,
   input  logic [mafh_pkg::FMT_W-1:0]       rsp_format_code
);

   // Every accepted transaction is followed by a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_valid)
      else $error("result missing six cycles after accept");

   // No result without a matching accept
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 6))
      else $error("result without a transaction");

   // Rejected frames report zero length and format
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_ok) |-> (rsp_frame_length == '0 && rsp_format_code == '0))
      else $error("rejected frame with nonzero fields");

   // Accepted frames carry a legal format and a plausible length
   a_ok_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_ok) |->
         (rsp_frame_length >= mafh_pkg::LEN_W'(mafh_pkg::MIN_LEN)
          && rsp_format_code[3:2] != 2'd0
          && rsp_format_code[5:4] != mafh_pkg::VER_RESERVED
          && rsp_format_code[1:0] != mafh_pkg::SRI_RSVD))
      else $error("accepted frame with illegal format or length");

endmodule

bind mpeg_audio_frame_header_decode mafh_checker u_checker (.*);
